FILE: src/prc_pkg.sv
// ---------------------------------------------------------------------------
// prc_pkg
// Shared constants, register indexes and control structs for the PID rate
// controller.
// ---------------------------------------------------------------------------
package prc_pkg;

    // Arithmetic sizing
    localparam int SUM_BITS       = 32;   // integral width, 20..48
    localparam int GAIN_FRAC_BITS = 12;   // gain fraction bits, 8..16

    localparam int DATA_W  = 16;
    localparam int ERR_W   = DATA_W + 1;            // target - measured
    localparam int DIFF_W  = ERR_W + 1;             // e - e_prev
    localparam int GAIN_W  = DATA_W + 1;            // gain with a zero sign bit
    localparam int P_W     = GAIN_W + ERR_W;
    localparam int I_W     = GAIN_W + SUM_BITS;
    localparam int D_W     = GAIN_W + DIFF_W;
    localparam int ACC_W   = I_W + 2;               // room for three terms
    localparam int SIN_W   = DATA_W + 1 + GAIN_FRAC_BITS; // acc up to the limit
    localparam int SCALE   = 100;
    localparam int SCALE_W = 7;
    localparam int SOUT_W  = SIN_W + SCALE_W;
    localparam int DRV_W   = SOUT_W - GAIN_FRAC_BITS;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FLOOR = 3'd4;

    localparam logic [DATA_W-1:0] RST_TARGET_RATE  = 16'd100;
    localparam logic [DATA_W-1:0] RST_PROP_GAIN    = 16'd819;
    localparam logic [DATA_W-1:0] RST_INTEG_GAIN   = 16'd61;
    localparam logic [DATA_W-1:0] RST_DERIV_GAIN   = 16'd819;
    localparam logic [DATA_W-1:0] RST_OUTPUT_FLOOR = 16'd500;

    // Controller -> datapath
    typedef struct packed {
        logic load;      // capture error of a new item
        logic sum_en;    // integral, difference, previous error
        logic mul_en;    // three gain products
        logic acc_en;    // sum of products
        logic scale_en;  // x100 and range flags
        logic out_load;  // clamp into the output register
    } prc_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_hold;  // output register full and not being taken
    } prc_status_t;

endpackage

FILE: src/prc_if.sv
// ---------------------------------------------------------------------------
// prc_in_if / prc_out_if
// Valid/ready channels carrying measurement and control items.
// ---------------------------------------------------------------------------
interface prc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] measured_rate;

    modport source (output valid, output measured_rate, input ready);
    modport sink   (input valid, input measured_rate, output ready);
endinterface

interface prc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] control_value;

    modport source (output valid, output control_value, input ready);
    modport sink   (input valid, input control_value, output ready);
endinterface

FILE: src/prc_ctrl.sv
// ---------------------------------------------------------------------------
// prc_ctrl
// Sequencer stepping one item through the PID datapath.
// ---------------------------------------------------------------------------
module prc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  prc_pkg::prc_status_t status,
    output prc_pkg::prc_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SUM   = 6'b000010,
        S_MUL   = 6'b000100,
        S_ACC   = 6'b001000,
        S_SCALE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_hold)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/prc_datapath.sv
// ---------------------------------------------------------------------------
// prc_datapath
// Configuration registers, PID arithmetic and the output register.
// ---------------------------------------------------------------------------
module prc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prc_pkg::DATA_W-1:0]          cfg_data,
    input  logic [prc_pkg::DATA_W-1:0]          measured_rate,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [prc_pkg::DATA_W-1:0]          control_value,
    input  prc_pkg::prc_cmd_t                   cmd,
    output prc_pkg::prc_status_t                status
);

    localparam int SB  = prc_pkg::SUM_BITS;
    localparam int GFB = prc_pkg::GAIN_FRAC_BITS;
    localparam int DW  = prc_pkg::DATA_W;
    localparam logic [prc_pkg::ACC_W-1:0] LIMIT =
        prc_pkg::ACC_W'(64'd1 << (DW + GFB));

    logic [DW-1:0] target_reg, pgain_reg, igain_reg, dgain_reg, floor_reg;

    logic signed [prc_pkg::ERR_W-1:0]  err_reg, prev_reg;
    logic signed [SB-1:0]              sum_reg;
    logic signed [prc_pkg::DIFF_W-1:0] diff_reg;
    logic signed [prc_pkg::P_W-1:0]    p_reg;
    logic signed [prc_pkg::I_W-1:0]    i_reg;
    logic signed [prc_pkg::D_W-1:0]    d_reg;
    logic signed [prc_pkg::ACC_W-1:0]  acc_reg;
    logic [prc_pkg::SOUT_W-1:0]        scaled_reg;
    logic                              nonpos_reg, over_reg;
    logic [DW-1:0]                     out_data_reg;
    logic                              out_valid_reg;

    logic signed [prc_pkg::ERR_W-1:0]  err_next;
    logic signed [SB:0]                sum_wide;
    logic signed [SB-1:0]              sum_next;
    logic signed [prc_pkg::P_W-1:0]    p_next;
    logic signed [prc_pkg::I_W-1:0]    i_next;
    logic signed [prc_pkg::D_W-1:0]    d_next;
    logic signed [prc_pkg::ACC_W-1:0]  acc_next;
    logic [prc_pkg::SOUT_W-1:0]        scaled_next;
    logic [prc_pkg::DRV_W-1:0]         drive_full;
    logic [DW-1:0]                     drive;
    logic [DW-1:0]                     out_data_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= prc_pkg::RST_TARGET_RATE;
            pgain_reg  <= prc_pkg::RST_PROP_GAIN;
            igain_reg  <= prc_pkg::RST_INTEG_GAIN;
            dgain_reg  <= prc_pkg::RST_DERIV_GAIN;
            floor_reg  <= prc_pkg::RST_OUTPUT_FLOOR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                prc_pkg::CFG_TARGET_RATE:  target_reg <= cfg_data;
                prc_pkg::CFG_PROP_GAIN:    pgain_reg  <= cfg_data;
                prc_pkg::CFG_INTEG_GAIN:   igain_reg  <= cfg_data;
                prc_pkg::CFG_DERIV_GAIN:   dgain_reg  <= cfg_data;
                prc_pkg::CFG_OUTPUT_FLOOR: floor_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Error and saturating integral
    assign err_next = $signed({1'b0, target_reg}) - $signed({1'b0, measured_rate});
    assign sum_wide = (SB + 1)'(sum_reg) + (SB + 1)'(err_reg);

    always_comb
    begin
        if (sum_wide[SB] != sum_wide[SB-1])
        begin
            sum_next = sum_wide[SB] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[SB-1:0];
        end
    end

    // Gain products, sum, scaling
    assign p_next = $signed({1'b0, pgain_reg}) * err_reg;
    assign i_next = $signed({1'b0, igain_reg}) * sum_reg;
    assign d_next = $signed({1'b0, dgain_reg}) * diff_reg;
    assign acc_next = prc_pkg::ACC_W'(p_reg) + prc_pkg::ACC_W'(i_reg)
                    + prc_pkg::ACC_W'(d_reg);
    assign scaled_next = prc_pkg::SOUT_W'(acc_reg[prc_pkg::SIN_W-1:0])
                       * prc_pkg::SOUT_W'(prc_pkg::SCALE);

    // Truncate the Q-format, then range and floor clamps
    assign drive_full = scaled_reg[prc_pkg::SOUT_W-1:GFB];

    always_comb
    begin
        priority if (nonpos_reg)
        begin
            drive = '0;
        end
        else if (over_reg || (drive_full[prc_pkg::DRV_W-1:DW] != '0))
        begin
            drive = '1;
        end
        else
        begin
            drive = drive_full[DW-1:0];
        end
        out_data_next = (drive < floor_reg) ? floor_reg : drive;
    end

    // Working state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else if (cmd.sum_en)
        begin
            sum_reg  <= sum_next;
            prev_reg <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= err_next;
        end
        if (cmd.sum_en)
        begin
            diff_reg <= prc_pkg::DIFF_W'(err_reg) - prc_pkg::DIFF_W'(prev_reg);
        end
        if (cmd.mul_en)
        begin
            p_reg <= p_next;
            i_reg <= i_next;
            d_reg <= d_next;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.scale_en)
        begin
            scaled_reg <= scaled_next;
            nonpos_reg <= acc_reg[prc_pkg::ACC_W-1] || (acc_reg == '0);
            over_reg   <= !acc_reg[prc_pkg::ACC_W-1] && ($unsigned(acc_reg) > LIMIT);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_hold = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign control_value   = out_data_reg;

endmodule

FILE: src/pid_rate_controller.sv
// An accepted item steps through the sequencer states error/integral,
// multiply, add, scale and output load, which waits while the output is held;
// result.valid rises after the load. A new item is taken only in idle.
// A finished item may wait in the output register while the next is worked.
// Reset (rst_n low, asynchronous): registers to their defaults, integral and
// previous error to zero, sequencer idle, output empty.
// ---------------------------------------------------------------------------
// pid_rate_controller
// Positional PID loop: drives a measured per-period event count toward a
// setpoint and emits a scaled, clamped control value per measurement.
// ---------------------------------------------------------------------------
module pid_rate_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prc_pkg::DATA_W-1:0]      cfg_data,
    prc_in_if.sink                          sample,
    prc_out_if.source                       result
);

    // Command and status between sequencer and datapath
    prc_pkg::prc_cmd_t    cmd;
    prc_pkg::prc_status_t status;

    // Sequencer: one item at a time; ready only while idle
    prc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: config registers, integral state, gain multipliers, x100
    // scaling, clamping to [floor, 65535] and the output register
    prc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .measured_rate (sample.measured_rate),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .control_value (result.control_value),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
